// ----- rtl/core/cbpt_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register indexes and types for the cubic Bezier point/tangent unit.
package cbpt_pkg;

  localparam int T_W     = 17;  // parameter, unsigned Q1.16 (one = 65536)
  localparam int CRD_W   = 16;  // packed coordinate, signed Q8.8
  localparam int CP_W    = 17;  // control point, signed Q9.8
  localparam int POS_W   = 17;  // position result
  localparam int DER_W   = 19;  // derivative result
  localparam int SQ_W    = 33;  // r^2, r*t, t^2 (max 2^32)
  localparam int W_W     = 49;  // Bernstein weights scaled by 2^48
  localparam int WLO_W   = 24;  // low split of a weight
  localparam int CFG_W   = 48;  // widest register
  localparam int CFG_IDX_W = 3;
  localparam int NSTG    = 6;   // pipeline register stages
  localparam int NAX     = 3;

  localparam logic [T_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE   = 3'd4;

  // Parameter-derived terms handed from the weight pipe to each axis.
  typedef struct packed {
    logic [T_W-1:0]            t;   // stage 0
    logic [SQ_W-1:0]           r2;  // stage 1
    logic [SQ_W-1:0]           rt;  // stage 1
    logic [SQ_W-1:0]           t2;  // stage 1
    logic [3:0][W_W-1:0]       w;   // stage 2
  } cbpt_wts_t;

endpackage

// ----- rtl/core/cbpt_weights.sv -----
`timescale 1ns / 1ps
// Weight pipe: clamps the parameter and forms the powers and Bernstein weights.
module cbpt_weights import cbpt_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [T_W-1:0]  in_param,
  output cbpt_wts_t       wts
);

  logic [T_W-1:0]  t0_r, r0_r, t1_r, r1_r;
  logic [T_W-1:0]  t0_nxt;
  logic [SQ_W-1:0] r2_r, rt_r, t2_r;
  logic [3:0][W_W-1:0] w_r;

  assign t0_nxt = (in_param > ONE_Q16) ? ONE_Q16 : in_param;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= t0_nxt;
      r0_r <= ONE_Q16 - t0_nxt;
      t1_r <= t0_r;
      r1_r <= r0_r;
      r2_r <= SQ_W'(r0_r) * SQ_W'(r0_r);
      rt_r <= SQ_W'(r0_r) * SQ_W'(t0_r);
      t2_r <= SQ_W'(t0_r) * SQ_W'(t0_r);
      w_r[0] <= W_W'(r2_r) * W_W'(r1_r);
      w_r[1] <= W_W'(3) * W_W'(rt_r) * W_W'(r1_r);
      w_r[2] <= W_W'(3) * W_W'(rt_r) * W_W'(t1_r);
      w_r[3] <= W_W'(t2_r) * W_W'(t1_r);
    end
  end

  assign wts.t  = t0_r;
  assign wts.r2 = r2_r;
  assign wts.rt = rt_r;
  assign wts.t2 = t2_r;
  assign wts.w  = w_r;

endmodule

// ----- rtl/core/cbpt_axis.sv -----
`timescale 1ns / 1ps
// One coordinate axis: weighted control point sum, derivative and line mode.
module cbpt_axis import cbpt_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    line_mode,
  input  logic signed [CRD_W-1:0] p,
  input  logic signed [CRD_W-1:0] l,
  input  logic signed [CRD_W-1:0] a,
  input  logic signed [CRD_W-1:0] q,
  input  cbpt_wts_t               wts,
  output logic signed [POS_W-1:0] pos,
  output logic signed [DER_W-1:0] der
);

  localparam int PRD_W = 43;  // weight half times control point
  localparam int SUM_W = 45;
  localparam int S_W   = 70;
  localparam int D_W   = 56;
  localparam int LA_W  = 36;
  localparam int M_W   = 18;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [21:0] v);
    if (v > 22'sd65535)       return 17'sd65535;
    else if (v < -22'sd65536) return -17'sd65536;
    else                      return v[POS_W-1:0];
  endfunction

  function automatic logic signed [DER_W-1:0] sat_der(input logic signed [23:0] v);
    if (v > 24'sd262143)       return 19'sd262143;
    else if (v < -24'sd262144) return -19'sd262144;
    else                       return v[DER_W-1:0];
  endfunction

  logic signed [CP_W-1:0]  cp [4];
  logic signed [CP_W-1:0]  chord;
  logic signed [M_W-1:0]   m;
  logic signed [T_W:0]     t_s;

  logic signed [LA_W-1:0]  lacc_r;
  logic signed [POS_W-1:0] lpos2_r, lpos3_r, lpos4_r;
  logic signed [D_W-1:0]   d0_r, d1_r, d2_r, dsum_r;
  logic signed [PRD_W-1:0] hi_r [4];
  logic signed [PRD_W-1:0] lo_r [4];
  logic signed [SUM_W-1:0] hsum_r, lsum_r;
  logic signed [DER_W-1:0] der4_r;
  logic signed [POS_W-1:0] pos_r;
  logic signed [DER_W-1:0] der_r;

  logic signed [LA_W-1:0]  lacc_rnd;
  logic signed [D_W-1:0]   dsum_rnd;
  logic signed [S_W-1:0]   s_full;
  logic signed [SUM_W-1:0] hsum_nxt, lsum_nxt;

  always_comb begin
    cp[0] = CP_W'(p);
    cp[1] = CP_W'(p) + CP_W'(l);
    cp[2] = CP_W'(q) + CP_W'(a);
    cp[3] = CP_W'(q);
    chord = CP_W'(q) - CP_W'(p);
    m     = M_W'(cp[2]) - M_W'(cp[1]);
    t_s   = $signed({1'b0, wts.t});
  end

  always_comb begin
    hsum_nxt = '0;
    lsum_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      hsum_nxt = hsum_nxt + SUM_W'(hi_r[k]);
      lsum_nxt = lsum_nxt + SUM_W'(lo_r[k]);
    end
  end

  assign lacc_rnd = lacc_r + LA_W'(32768);
  assign dsum_rnd = dsum_r + (D_W'(1) <<< 31);
  assign s_full   = (S_W'(hsum_r) <<< 24) + S_W'(lsum_r) + (S_W'(1) <<< 47);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      lacc_r  <= (LA_W'(p) <<< 16) + LA_W'(chord) * LA_W'(t_s);
      // stage 2
      lpos2_r <= $signed(lacc_rnd[16 +: POS_W]);
      d0_r    <= D_W'(3) * D_W'($signed({1'b0, wts.r2})) * D_W'(l);
      d1_r    <= D_W'(6) * D_W'($signed({1'b0, wts.rt})) * D_W'(m);
      d2_r    <= D_W'(3) * D_W'($signed({1'b0, wts.t2})) * D_W'(a);
      // stage 3
      lpos3_r <= lpos2_r;
      for (int k = 0; k < 4; k++) begin
        hi_r[k] <= PRD_W'($signed({1'b0, wts.w[k][W_W-1:WLO_W]})) * PRD_W'(cp[k]);
        lo_r[k] <= PRD_W'($signed({1'b0, wts.w[k][WLO_W-1:0]})) * PRD_W'(cp[k]);
      end
      dsum_r  <= d0_r + d1_r - d2_r;
      // stage 4
      lpos4_r <= lpos3_r;
      hsum_r  <= hsum_nxt;
      lsum_r  <= lsum_nxt;
      der4_r  <= sat_der($signed(dsum_rnd[D_W-1:32]));
      // stage 5
      pos_r   <= line_mode ? lpos4_r : sat_pos($signed(s_full[S_W-1:48]));
      der_r   <= line_mode ? DER_W'(chord) : der4_r;
    end
  end

  assign pos = pos_r;
  assign der = der_r;

endmodule

// ----- rtl/core/cubic_bezier_point_tangent_unit.sv -----
`timescale 1ns / 1ps
// Top level of the cubic Bezier point/tangent unit.
// Each parameter beat gives one result beat: the segment position (Q9.8) and raw first
// derivative (Q11.8), both saturated; in line mode the chord interpolation and the chord.
// The datapath is a six-register pipeline, so a beat can be taken every cycle while the pipe
// is not held; its result is valid on the outputs once it reaches the last register. While a
// finished result waits for out_ready, the whole pipe holds. Configuration writes take effect
// at the next edge and must be made only while the unit is idle; the unit does not check it.
module cubic_bezier_point_tangent_unit import cbpt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [T_W-1:0]          in_param,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  output logic signed [DER_W-1:0] out_deriv_x,
  output logic signed [DER_W-1:0] out_deriv_y,
  output logic signed [DER_W-1:0] out_deriv_z
);

  logic [CFG_W-1:0] start_r, leave_r, arrive_r, end_r;
  logic             line_r;
  logic [NSTG-1:0]  v_r;
  logic             en;
  cbpt_wts_t        wts;
  logic signed [POS_W-1:0] pos [NAX];
  logic signed [DER_W-1:0] der [NAX];

  assign en        = !v_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      leave_r  <= '0;
      arrive_r <= '0;
      end_r    <= '0;
      line_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:  start_r  <= cfg_wdata;
        REG_LEAVE:  leave_r  <= cfg_wdata;
        REG_ARRIVE: arrive_r <= cfg_wdata;
        REG_END:    end_r    <= cfg_wdata;
        REG_LINE:   line_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  cbpt_weights u_weights (
    .clk      (clk),
    .en       (en),
    .in_param (in_param),
    .wts      (wts)
  );

  for (genvar ax = 0; ax < NAX; ax++) begin : g_axis
    cbpt_axis u_axis (
      .clk       (clk),
      .en        (en),
      .line_mode (line_r),
      .p         ($signed(start_r[CRD_W*ax +: CRD_W])),
      .l         ($signed(leave_r[CRD_W*ax +: CRD_W])),
      .a         ($signed(arrive_r[CRD_W*ax +: CRD_W])),
      .q         ($signed(end_r[CRD_W*ax +: CRD_W])),
      .wts       (wts),
      .pos       (pos[ax]),
      .der       (der[ax])
    );
  end

  assign out_pos_x   = pos[0];
  assign out_pos_y   = pos[1];
  assign out_pos_z   = pos[2];
  assign out_deriv_x = der[0];
  assign out_deriv_y = der[1];
  assign out_deriv_z = der[2];

endmodule
